### hdl/asc_pkg.sv
// Shared codes and control types of the allocation safety checker.
// No dependencies.
package asc_pkg;

  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_ACCESS = 2'd1;
  localparam logic [1:0] ACT_FREE   = 2'd2;

  localparam logic [1:0] EV_ALLOC  = 2'd0;
  localparam logic [1:0] EV_ACCESS = 2'd1;
  localparam logic [1:0] EV_FREE   = 2'd2;

  localparam logic [2:0] ST_OK                = 3'd0;
  localparam logic [2:0] ST_USE_BEFORE_MALLOC = 3'd1;
  localparam logic [2:0] ST_USE_AFTER_FREE    = 3'd2;
  localparam logic [2:0] ST_INVALID_FREE      = 3'd3;
  localparam logic [2:0] ST_DOUBLE_FREE       = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL        = 3'd5;

  localparam int unsigned SIZE_BITS = 32;

  // Table update broadcast to every cell.
  typedef struct packed {
    logic       alloc_we;
    logic       ev_we;
    logic [1:0] ev;
  } upd_t;

  // Search flags handed from cell to cell.
  typedef struct packed {
    logic       ex_found;
    logic       cv_found;
    logic [1:0] ex_ev;
    logic [1:0] cv_ev;
  } hit_t;

endpackage

### hdl/asc_if.sv
// Valid/ready stream interfaces for event items and result items.
// Depends on asc_pkg.
interface asc_evt_if #(
  parameter int ADDR_BITS = 48
);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic [ADDR_BITS-1:0]            address;
  logic [asc_pkg::SIZE_BITS-1:0]   block_size;

  modport source (output valid, action, address, block_size, input ready);
  modport sink   (input valid, action, address, block_size, output ready);
endinterface

interface asc_res_if #(
  parameter int ADDR_BITS = 48,
  parameter int IDX_W     = 6
);
  logic                            valid;
  logic                            ready;
  logic [2:0]                      status;
  logic                            match_found;
  logic [IDX_W-1:0]                match_index;
  logic [ADDR_BITS-1:0]            match_start;
  logic [asc_pkg::SIZE_BITS-1:0]   match_size;
  logic [1:0]                      prior_event;

  modport source (output valid, status, match_found, match_index, match_start,
                  match_size, prior_event, input ready);
  modport sink   (input valid, status, match_found, match_index, match_start,
                  match_size, prior_event, output ready);
endinterface

### hdl/asc_cell.sv
// One table slot: holds an entry and refines the newest-first search item
// passing down the chain. Depends on asc_pkg.
module asc_cell #(
  parameter int IDX_W     = 6,
  parameter int ADDR_BITS = 48,
  parameter int CELL_IDX  = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ADDR_BITS-1:0]          cmd_addr_i,
  input  logic [asc_pkg::SIZE_BITS-1:0] cmd_size_i,
  input  asc_pkg::upd_t                 upd_i,
  input  logic [IDX_W-1:0]              upd_idx_i,
  input  asc_pkg::hit_t                 hit_i,
  input  logic [IDX_W-1:0]              ex_idx_i,
  input  logic [ADDR_BITS-1:0]          ex_start_i,
  input  logic [asc_pkg::SIZE_BITS-1:0] ex_size_i,
  input  logic [IDX_W-1:0]              cv_idx_i,
  input  logic [ADDR_BITS-1:0]          cv_start_i,
  input  logic [asc_pkg::SIZE_BITS-1:0] cv_size_i,
  output asc_pkg::hit_t                 hit_o,
  output logic [IDX_W-1:0]              ex_idx_o,
  output logic [ADDR_BITS-1:0]          ex_start_o,
  output logic [asc_pkg::SIZE_BITS-1:0] ex_size_o,
  output logic [IDX_W-1:0]              cv_idx_o,
  output logic [ADDR_BITS-1:0]          cv_start_o,
  output logic [asc_pkg::SIZE_BITS-1:0] cv_size_o
);

  localparam int CW = (ADDR_BITS > asc_pkg::SIZE_BITS) ? ADDR_BITS : asc_pkg::SIZE_BITS;
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                          valid_q;
  logic [ADDR_BITS-1:0]          start_q;
  logic [asc_pkg::SIZE_BITS-1:0] size_q;
  logic [1:0]                    ev_q;

  logic                          sel;
  logic                          exact;
  logic                          covers;
  logic [CW-1:0]                 diff;

  asc_pkg::hit_t                 hit_d, hit_q;
  logic [IDX_W-1:0]              ex_idx_d, ex_idx_q, cv_idx_d, cv_idx_q;
  logic [ADDR_BITS-1:0]          ex_start_d, ex_start_q, cv_start_d, cv_start_q;
  logic [asc_pkg::SIZE_BITS-1:0] ex_size_d, ex_size_q, cv_size_d, cv_size_q;

  assign sel    = (upd_idx_i == MY_IDX);
  assign diff   = CW'(cmd_addr_i) - CW'(start_q);
  assign exact  = valid_q && (start_q == cmd_addr_i);
  assign covers = valid_q && (cmd_addr_i >= start_q) && (diff < CW'(size_q));

  always_comb begin
    hit_d      = hit_i;
    ex_idx_d   = ex_idx_i;
    ex_start_d = ex_start_i;
    ex_size_d  = ex_size_i;
    cv_idx_d   = cv_idx_i;
    cv_start_d = cv_start_i;
    cv_size_d  = cv_size_i;
    if (!hit_i.ex_found && exact) begin
      hit_d.ex_found = 1'b1;
      hit_d.ex_ev    = ev_q;
      ex_idx_d       = MY_IDX;
      ex_start_d     = start_q;
      ex_size_d      = size_q;
    end
    if (!hit_i.cv_found && covers) begin
      hit_d.cv_found = 1'b1;
      hit_d.cv_ev    = ev_q;
      cv_idx_d       = MY_IDX;
      cv_start_d     = start_q;
      cv_size_d      = size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= '0;
    end else begin
      hit_q <= hit_d;
      if (upd_i.alloc_we && sel) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ex_idx_q   <= ex_idx_d;
    ex_start_q <= ex_start_d;
    ex_size_q  <= ex_size_d;
    cv_idx_q   <= cv_idx_d;
    cv_start_q <= cv_start_d;
    cv_size_q  <= cv_size_d;
    if (upd_i.alloc_we && sel) begin
      start_q <= cmd_addr_i;
      size_q  <= cmd_size_i;
      ev_q    <= asc_pkg::EV_ALLOC;
    end else if (upd_i.ev_we && sel) begin
      ev_q <= upd_i.ev;
    end
  end

  assign hit_o      = hit_q;
  assign ex_idx_o   = ex_idx_q;
  assign ex_start_o = ex_start_q;
  assign ex_size_o  = ex_size_q;
  assign cv_idx_o   = cv_idx_q;
  assign cv_start_o = cv_start_q;
  assign cv_size_o  = cv_size_q;

endmodule

### hdl/allocation_safety_checker_unit.sv
// Top level of the allocation safety checker: control, result register and
// the chain of asc_cell slots. Depends on asc_pkg, asc_if.sv and asc_cell.
//
// Tracks up to TABLE_DEPTH allocations, one per cell, and checks each event
// item (allocate, access, free) against them, returning one status item per
// event. One item is in work at a time. An allocate or an unused action goes
// straight from acceptance to the finish state, which loads its result. An
// access or free first passes through the search state while the search item
// walks the cell chain from the newest slot down to slot 0, one cell per clock,
// and the winning entry is then reported and updated in the finish state. The
// next item is accepted the cycle after the result is loaded, even while that
// result still waits to be taken; an item that finishes while that result is
// still held waits in the finish state.
module allocation_safety_checker_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int ADDR_BITS   = 48
) (
  input logic         clk_i,
  input logic         rst_ni,
  asc_evt_if.sink     evt_i,
  asc_res_if.source   res_o
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SW    = asc_pkg::SIZE_BITS;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [1:0]           act_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [SW-1:0]        size_q;

  logic                 out_valid_q, out_valid_d;
  logic [2:0]           status_q, status_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     index_q, index_d;
  logic [ADDR_BITS-1:0] mstart_q, mstart_d;
  logic [SW-1:0]        msize_q, msize_d;
  logic [1:0]           prior_q, prior_d;

  logic                 accept;
  logic                 fin_ok;
  logic                 full;
  asc_pkg::upd_t        upd, upd_raw;
  logic [IDX_W-1:0]     upd_idx;

  asc_pkg::hit_t        hit      [TABLE_DEPTH+1];
  logic [IDX_W-1:0]     ex_idx   [TABLE_DEPTH+1];
  logic [ADDR_BITS-1:0] ex_start [TABLE_DEPTH+1];
  logic [SW-1:0]        ex_size  [TABLE_DEPTH+1];
  logic [IDX_W-1:0]     cv_idx   [TABLE_DEPTH+1];
  logic [ADDR_BITS-1:0] cv_start [TABLE_DEPTH+1];
  logic [SW-1:0]        cv_size  [TABLE_DEPTH+1];

  assign hit[TABLE_DEPTH]      = '0;
  assign ex_idx[TABLE_DEPTH]   = '0;
  assign ex_start[TABLE_DEPTH] = '0;
  assign ex_size[TABLE_DEPTH]  = '0;
  assign cv_idx[TABLE_DEPTH]   = '0;
  assign cv_start[TABLE_DEPTH] = '0;
  assign cv_size[TABLE_DEPTH]  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    asc_cell #(
      .IDX_W     (IDX_W),
      .ADDR_BITS (ADDR_BITS),
      .CELL_IDX  (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_addr_i (addr_q),
      .cmd_size_i (size_q),
      .upd_i      (upd),
      .upd_idx_i  (upd_idx),
      .hit_i      (hit[i+1]),
      .ex_idx_i   (ex_idx[i+1]),
      .ex_start_i (ex_start[i+1]),
      .ex_size_i  (ex_size[i+1]),
      .cv_idx_i   (cv_idx[i+1]),
      .cv_start_i (cv_start[i+1]),
      .cv_size_i  (cv_size[i+1]),
      .hit_o      (hit[i]),
      .ex_idx_o   (ex_idx[i]),
      .ex_start_o (ex_start[i]),
      .ex_size_o  (ex_size[i]),
      .cv_idx_o   (cv_idx[i]),
      .cv_start_o (cv_start[i]),
      .cv_size_o  (cv_size[i])
    );
  end

  assign evt_i.ready = (state_q == S_IDLE);
  assign accept      = evt_i.valid && evt_i.ready;
  assign fin_ok      = (state_q == S_FINISH) && (!out_valid_q || res_o.ready);
  assign full        = (count_q == CNT_W'(TABLE_DEPTH));

  // Result and table update; access/free use the item leaving slot 0.
  always_comb begin
    status_d = asc_pkg::ST_OK;
    found_d  = 1'b0;
    index_d  = '0;
    mstart_d = '0;
    msize_d  = '0;
    prior_d  = asc_pkg::EV_ALLOC;
    upd_raw  = '0;
    upd_idx  = '0;
    unique case (act_q)
      asc_pkg::ACT_ALLOC: begin
        if (full) begin
          status_d = asc_pkg::ST_TABLE_FULL;
        end else begin
          index_d          = count_q[IDX_W-1:0];
          upd_idx          = count_q[IDX_W-1:0];
          upd_raw.alloc_we = 1'b1;
        end
      end
      asc_pkg::ACT_ACCESS: begin
        if (!hit[0].cv_found) begin
          status_d = asc_pkg::ST_USE_BEFORE_MALLOC;
        end else begin
          found_d  = 1'b1;
          index_d  = cv_idx[0];
          mstart_d = cv_start[0];
          msize_d  = cv_size[0];
          prior_d  = hit[0].cv_ev;
          upd_idx  = cv_idx[0];
          if (hit[0].cv_ev == asc_pkg::EV_FREE) begin
            status_d = asc_pkg::ST_USE_AFTER_FREE;
          end else begin
            upd_raw.ev_we = 1'b1;
            upd_raw.ev    = asc_pkg::EV_ACCESS;
          end
        end
      end
      asc_pkg::ACT_FREE: begin
        if (hit[0].ex_found) begin
          found_d  = 1'b1;
          index_d  = ex_idx[0];
          mstart_d = ex_start[0];
          msize_d  = ex_size[0];
          prior_d  = hit[0].ex_ev;
          upd_idx  = ex_idx[0];
          if (hit[0].ex_ev == asc_pkg::EV_FREE) begin
            status_d = asc_pkg::ST_DOUBLE_FREE;
          end else begin
            upd_raw.ev_we = 1'b1;
            upd_raw.ev    = asc_pkg::EV_FREE;
          end
        end else begin
          status_d = asc_pkg::ST_INVALID_FREE;
          if (hit[0].cv_found) begin
            found_d  = 1'b1;
            index_d  = cv_idx[0];
            mstart_d = cv_start[0];
            msize_d  = cv_size[0];
            prior_d  = hit[0].cv_ev;
          end
        end
      end
      default: begin
      end
    endcase
    upd          = upd_raw;
    upd.alloc_we = upd_raw.alloc_we && fin_ok;
    upd.ev_we    = upd_raw.ev_we && fin_ok;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          if (evt_i.action == asc_pkg::ACT_ACCESS || evt_i.action == asc_pkg::ACT_FREE) begin
            state_d = S_SEARCH;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SEARCH: begin
        if (cnt_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (fin_ok) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          if (upd.alloc_we) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= evt_i.action;
      addr_q <= evt_i.address;
      size_q <= evt_i.block_size;
    end
    if (fin_ok) begin
      status_q <= status_d;
      found_q  <= found_d;
      index_q  <= index_d;
      mstart_q <= mstart_d;
      msize_q  <= msize_d;
      prior_q  <= prior_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = status_q;
  assign res_o.match_found = found_q;
  assign res_o.match_index = index_q;
  assign res_o.match_start = mstart_q;
  assign res_o.match_size  = msize_q;
  assign res_o.prior_event = prior_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd.alloc_we |-> !full)
    else $error("allocate written into a full table");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("item accepted but control stayed idle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_ok && status_d == asc_pkg::ST_TABLE_FULL |-> act_q == asc_pkg::ACT_ALLOC && full)
    else $error("table full reported while room remains");
`endif

endmodule
